[src/afu_pkg.sv]
// Package for the activation function unit: fixed-point format, command codes,
// pipeline control types and the sigmoid lookup table built at elaboration.
// No dependencies.
package afu_pkg;

  // Fixed-point format and table geometry.
  localparam int unsigned FRAC_BITS      = 12;
  localparam int unsigned TABLE_SEGMENTS = 256;
  localparam int unsigned OP_W           = 16;
  localparam int unsigned VAL_W          = 15;
  localparam int unsigned ONE            = 1 << FRAC_BITS;
  localparam int unsigned SEG_W_RAW      = (1 << (FRAC_BITS + 3)) / TABLE_SEGMENTS;
  localparam int unsigned SEG_W          = (SEG_W_RAW != 0) ? SEG_W_RAW : 1;
  localparam int unsigned SAT_LIMIT      = 8 << FRAC_BITS;
  localparam int unsigned ROM_W          = FRAC_BITS + 1;
  localparam int unsigned IDX_W          = $clog2(TABLE_SEGMENTS + 1);
  localparam int unsigned REM_W          = (SEG_W > 1) ? $clog2(SEG_W) : 1;
  localparam int unsigned PROD_W         = ROM_W + REM_W + 1;
  localparam int unsigned MUL_W          = 2 * ROM_W;
  localparam int unsigned NUM_STAGES     = 6;

  typedef enum logic [1:0] {
    CMD_RELU          = 2'd0,
    CMD_SIGMOID       = 2'd1,
    CMD_RELU_DERIV    = 2'd2,
    CMD_SIGMOID_DERIV = 2'd3
  } cmd_e;

  typedef logic [ROM_W-1:0] rom_word_t;
  typedef rom_word_t rom_t [TABLE_SEGMENTS+1];

  // Per-item control fields that ride along the pipeline.
  typedef struct packed {
    cmd_e             cmd;
    logic             neg;
    logic             sat;
    logic             pos;
    logic [VAL_W-1:0] relu;
  } ctl_t;

  localparam logic [63:0] Q62_ONE = 64'd1 << 62;

  // (a * b) >> 62 over the full 128-bit product.
  function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // Unsigned long division, one quotient bit per step.
  function automatic logic [63:0] div_u64(logic [63:0] num, logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // round(ONE / (1 + e)) with e in Q62.
  function automatic rom_word_t logistic_entry(logic [63:0] e);
    logic [64:0] d;
    logic [64:0] r;
    logic [63:0] q;
    logic [63:0] qr;
    d = {1'b0, Q62_ONE} + {1'b0, e};
    r = {1'b0, Q62_ONE};
    q = '0;
    for (int i = 0; i < int'(FRAC_BITS) + 1; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r    = r - d;
        q[0] = 1'b1;
      end
    end
    qr = (q + 64'd1) >> 1;
    return qr[ROM_W-1:0];
  endfunction

  // Sigmoid table: entry k is the logistic of k segment widths.
  function automatic rom_t build_rom();
    rom_t        rom;
    logic [63:0] y;
    logic [63:0] term;
    logic [63:0] ey;
    logic [63:0] e;
    y    = 64'(SEG_W) << (62 - FRAC_BITS);
    term = Q62_ONE;
    ey   = Q62_ONE;
    e    = Q62_ONE;
    // Series for exp(-y).
    for (int n = 1; n < 40; n++) begin
      term = div_u64(mul_q62(term, y), 64'(n));
      if ((n % 2) == 1) begin
        ey = ey - term;
      end else begin
        ey = ey + term;
      end
    end
    for (int k = 0; k <= int'(TABLE_SEGMENTS); k++) begin
      rom[k] = logistic_entry(e);
      e      = mul_q62(e, ey);
    end
    return rom;
  endfunction

  localparam rom_t SigRom = build_rom();

endpackage

[src/afu_if.sv]
// Handshake channels of the activation function unit: request and response.
// Depends on afu_pkg for field widths.
interface afu_req_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       command;
  logic signed [afu_pkg::OP_W-1:0]  operand;

  modport source (output valid, output command, output operand, input ready);
  modport sink   (input valid, input command, input operand, output ready);
endinterface

interface afu_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [afu_pkg::VAL_W-1:0]        value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

[src/afu_seg_lookup.sv]
// Sigmoid table lookup stage: registers the base entry of a segment and its
// slope to the next entry. Depends on afu_pkg for the table and widths.
module afu_seg_lookup (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [afu_pkg::IDX_W-1:0]    idx_i,
  output logic [afu_pkg::ROM_W-1:0]    lo_o,
  output logic [afu_pkg::ROM_W-1:0]    diff_o
);
  import afu_pkg::*;

  rom_word_t lo_d, hi_d, diff_d;
  rom_word_t lo_q, diff_q;

  // Read both segment ends; the last entry is its own upper end.
  always_comb begin
    lo_d = SigRom[idx_i];
    if (32'(idx_i) >= TABLE_SEGMENTS) begin
      hi_d = lo_d;
    end else begin
      hi_d = SigRom[idx_i + IDX_W'(1)];
    end
    diff_d = (hi_d < lo_d) ? '0 : (hi_d - lo_d);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_q   <= lo_d;
      diff_q <= diff_d;
    end
  end

  assign lo_o   = lo_q;
  assign diff_o = diff_q;

endmodule

[src/activation_function_unit.sv]
// Activation function unit: ReLU, sigmoid and their derivatives on Q4.12 items.
// Depends on afu_pkg, afu_req_if, afu_rsp_if and afu_seg_lookup.
//
//   channel  | direction | payload
//   req_i    | in        | command (2 b), operand (16 b signed Q4.12)
//   rsp_o    | out       | value (15 b unsigned Q3.12)
//
// Six register stages: split and index, table read, slope multiply, sigmoid
// combine, derivative multiply, output select. One item enters per cycle while
// rsp_o is not stalled; the two multipliers set the stage depth.
// Reset clears only the valid bits; the data registers are not reset.
// A stall on rsp_o fills the empty stages first, so req_i stays ready while
// any stage holds a bubble.
module activation_function_unit (
  input  logic     clk_i,
  input  logic     rst_ni,
  afu_req_if.sink  req_i,
  afu_rsp_if.source rsp_o
);
  import afu_pkg::*;

  logic [NUM_STAGES-1:0] valid_q, valid_d;
  logic [NUM_STAGES-1:0] adv;

  // Stage 1 signals.
  logic [OP_W-1:0]  mag;
  logic [OP_W-1:0]  quot;
  logic [OP_W-1:0]  rem_full;
  logic             neg, past, pos;
  ctl_t             ctl_d;
  ctl_t             ctl1_q, ctl2_q, ctl3_q, ctl4_q, ctl5_q;
  logic [IDX_W-1:0] idx1_d, idx1_q;
  logic [REM_W-1:0] rem1_q, rem2_q;

  // Later stages.
  rom_word_t        lo2, diff2, lo3_q;
  logic [PROD_W-1:0] prod3_d, prod3_q;
  rom_word_t        f4, s4_d, s4_q, s5_q;
  logic [MUL_W-1:0] m5_d, m5_q;
  logic [VAL_W-1:0] value_d, value_q;

  // Stage advance: a stage moves when it is empty or its successor moves.
  always_comb begin
    adv[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || rsp_o.ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      adv[k] = !valid_q[k] || adv[k+1];
    end
    valid_d[0] = adv[0] ? req_i.valid : valid_q[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      valid_d[k] = adv[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign req_i.ready = adv[0];

  // Stage 1: magnitude, saturation and segment split.
  always_comb begin
    neg      = req_i.operand[OP_W-1];
    mag      = neg ? (~req_i.operand + OP_W'(1)) : req_i.operand;
    quot     = OP_W'(mag / SEG_W);
    rem_full = OP_W'(mag % SEG_W);
    past     = 32'(quot) >= TABLE_SEGMENTS;
    idx1_d   = past ? IDX_W'(TABLE_SEGMENTS) : quot[IDX_W-1:0];
    pos      = !neg && (req_i.operand != '0);
    ctl_d.cmd  = cmd_e'(req_i.command);
    ctl_d.neg  = neg;
    ctl_d.sat  = 32'(mag) >= SAT_LIMIT;
    ctl_d.pos  = pos;
    ctl_d.relu = pos ? req_i.operand[VAL_W-1:0] : '0;
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      ctl1_q <= ctl_d;
      idx1_q <= idx1_d;
      rem1_q <= past ? '0 : rem_full[REM_W-1:0];
    end
  end

  // Stage 2: table read of the segment ends.
  afu_seg_lookup u_lookup (
    .clk_i  (clk_i),
    .en_i   (adv[1]),
    .idx_i  (idx1_q),
    .lo_o   (lo2),
    .diff_o (diff2)
  );

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      ctl2_q <= ctl1_q;
      rem2_q <= rem1_q;
    end
  end

  // Stage 3: slope times offset, with half a segment for rounding.
  assign prod3_d = PROD_W'(diff2) * PROD_W'(rem2_q) + PROD_W'(SEG_W / 2);

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      ctl3_q  <= ctl2_q;
      lo3_q   <= lo2;
      prod3_q <= prod3_d;
    end
  end

  // Stage 4: interpolated sigmoid, saturation and mirror for negative inputs.
  always_comb begin
    f4 = lo3_q + ROM_W'(prod3_q / SEG_W);
    if (ctl3_q.sat) begin
      f4 = ROM_W'(ONE);
    end
    s4_d = ctl3_q.neg ? (ROM_W'(ONE) - f4) : f4;
  end

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      ctl4_q <= ctl3_q;
      s4_q   <= s4_d;
    end
  end

  // Stage 5: sigmoid derivative product s * (1 - s), rounded.
  assign m5_d = MUL_W'(s4_q) * MUL_W'(ROM_W'(ONE) - s4_q) + MUL_W'(ONE / 2);

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      ctl5_q <= ctl4_q;
      s5_q   <= s4_q;
      m5_q   <= m5_d;
    end
  end

  // Stage 6: pick the result for the command.
  always_comb begin
    case (ctl5_q.cmd)
      CMD_RELU:          value_d = ctl5_q.relu;
      CMD_SIGMOID:       value_d = VAL_W'(s5_q);
      CMD_RELU_DERIV:    value_d = ctl5_q.pos ? VAL_W'(ONE) : '0;
      CMD_SIGMOID_DERIV: value_d = VAL_W'(m5_q >> FRAC_BITS);
      default:           value_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      value_q <= value_d;
    end
  end

  assign rsp_o.valid = valid_q[NUM_STAGES-1];
  assign rsp_o.value = value_q;

  // The combined sigmoid never exceeds one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[3] |-> (32'(s4_q) <= ONE))
    else $error("sigmoid stage value above one");

  // ReLU derivative results are exactly one or zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[4] && adv[5] && (ctl5_q.cmd == CMD_RELU_DERIV))
      |=> (32'(rsp_o.value) == ONE || rsp_o.value == '0))
    else $error("relu derivative result not one or zero");

  // The sigmoid derivative peaks at one quarter.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[4] && adv[5] && (ctl5_q.cmd == CMD_SIGMOID_DERIV))
      |=> (32'(rsp_o.value) <= ONE / 4))
    else $error("sigmoid derivative above one quarter");

endmodule
